/* sv/fowq_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the fcfs owner arbiter
package fowq_pkg;

    // fixed widths of the item fields
    localparam int ID_BITS  = 16;
    localparam int CNT_BITS = 6;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_OUT
    } t_state;

    // one result item
    typedef struct packed {
        logic                denied;
        logic [ID_BITS-1:0]  owner_id;
        logic                owner_valid;
        logic                newly_queued;
        logic                dropped_full;
        logic [CNT_BITS-1:0] waiting_count;
    } t_result;

endpackage

/* sv/fowq_req_if.sv */
`timescale 1ns / 1ps
// request channel: requester id and finished flag with valid/ready
interface fowq_req_if;
    logic                         valid;
    logic                         ready;
    logic [fowq_pkg::ID_BITS-1:0] requester_id;
    logic                         finished;

    modport source (output valid, output requester_id, output finished, input ready);
    modport sink   (input valid, input requester_id, input finished, output ready);
endinterface

/* sv/fowq_res_if.sv */
`timescale 1ns / 1ps
// result channel: grant decision, owner and queue status with valid/ready
interface fowq_res_if;
    logic                          valid;
    logic                          ready;
    logic                          denied;
    logic [fowq_pkg::ID_BITS-1:0]  owner_id;
    logic                          owner_valid;
    logic                          newly_queued;
    logic                          dropped_full;
    logic [fowq_pkg::CNT_BITS-1:0] waiting_count;

    modport source (
        output valid, output denied, output owner_id, output owner_valid,
        output newly_queued, output dropped_full, output waiting_count,
        input ready
    );
    modport sink (
        input valid, input denied, input owner_id, input owner_valid,
        input newly_queued, input dropped_full, input waiting_count,
        output ready
    );
endinterface

/* sv/fowq_out_stage.sv */
`timescale 1ns / 1ps
// output register that holds one result item until the receiver takes it
module fowq_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  fowq_pkg::t_result  i_result,
    output logic               o_free,
    fowq_res_if.source         o_res
);

    logic              r_vld;
    fowq_pkg::t_result r_data;

    // slot can take a new item when empty or being drained this cycle
    assign o_free = !r_vld || o_res.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    // payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_res.valid         = r_vld;
    assign o_res.denied        = r_data.denied;
    assign o_res.owner_id      = r_data.owner_id;
    assign o_res.owner_valid   = r_data.owner_valid;
    assign o_res.newly_queued  = r_data.newly_queued;
    assign o_res.dropped_full  = r_data.dropped_full;
    assign o_res.waiting_count = r_data.waiting_count;

endmodule

/* sv/fcfs_owner_arbiter_with_wait_queue.sv */
`timescale 1ns / 1ps
// top level: first-come-first-served owner arbiter with a ring wait queue
//
// Usage: each request item on i_req carries a requester id and a finished
// flag. With no owner the requester takes ownership. The owner is granted;
// when it reports finished, ownership moves to the oldest waiting id or the
// block goes idle. Any other requester is denied and appended to the wait
// queue unless it already waits there or the queue is full (dropped_full).
// One result item per request leaves on o_res.
// Throughput: one item at a time; the next request is taken only once the
// result of the last is loaded into the output register. A grant passes
// through ST_OUT, a handover to a waiting id through ST_POP and ST_OUT, and
// a denial through ST_SCAN and ST_OUT, with up to QUEUE_DEPTH - 1 entries
// waiting. The denial time is set by the duplicate scan, which reads the
// wait queue memory one entry per cycle through its single read port.
// Reset: owner idle, queue empty; the queue memory needs no clearing since
// only occupied entries are read. When o_res stalls, the finished result
// waits in the output register and the block still accepts the next item,
// then holds it until the register frees up.
module fcfs_owner_arbiter_with_wait_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_WIDTH    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fowq_req_if.sink    i_req,
    fowq_res_if.source  o_res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OID_W = fowq_pkg::ID_BITS;
    localparam int CNT_W = fowq_pkg::CNT_BITS;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    fowq_pkg::t_state r_state, n_state;

    logic [ID_WIDTH-1:0] r_owner, n_owner;
    logic                r_owner_vld, n_owner_vld;
    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [PTR_W-1:0]    r_count, n_count;
    logic [PTR_W-1:0]    r_scan, n_scan;
    logic                r_rd_vld, n_rd_vld;
    logic [ID_WIDTH-1:0] r_id, n_id;
    logic                r_denied, n_denied;
    logic                r_queued, n_queued;
    logic                r_dropped, n_dropped;

    // wait queue memory, one write and one registered read port
    logic [ID_WIDTH-1:0] r_ring [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] r_ring_q;
    logic                w_rd_en;
    logic [PTR_W-1:0]    w_rd_addr;
    logic                w_wr_en;

    logic                w_accept;
    logic [ID_WIDTH-1:0] w_id;
    logic                w_grant;
    logic                w_hit;
    logic                w_full;
    logic                w_load;
    logic                w_free;
    logic [PTR_W-1:0]    w_head_nx;
    logic [PTR_W-1:0]    w_tail_nx;
    logic [PTR_W-1:0]    w_scan_nx;
    fowq_pkg::t_result   w_result;

    assign i_req.ready = i_rst_n && (r_state == fowq_pkg::ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_id        = ID_WIDTH'(i_req.requester_id);
    assign w_grant     = !r_owner_vld || (r_owner == w_id);

    // ring pointer increments with wrap
    assign w_head_nx = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
    assign w_tail_nx = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
    assign w_scan_nx = (r_scan == PTR_LAST) ? '0 : r_scan + 1'b1;
    assign w_full    = (w_tail_nx == r_head);

    // scan compare on the entry read in the previous cycle
    assign w_hit = r_rd_vld && (r_ring_q == r_id);

    // state register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fowq_pkg::ST_IDLE;
            r_owner     <= '0;
            r_owner_vld <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_owner     <= n_owner;
            r_owner_vld <= n_owner_vld;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        r_scan    <= n_scan;
        r_id      <= n_id;
        r_denied  <= n_denied;
        r_queued  <= n_queued;
        r_dropped <= n_dropped;
    end

    // next state and memory control
    always_comb begin
        n_state     = r_state;
        n_owner     = r_owner;
        n_owner_vld = r_owner_vld;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_scan      = r_scan;
        n_rd_vld    = r_rd_vld;
        n_id        = r_id;
        n_denied    = r_denied;
        n_queued    = r_queued;
        n_dropped   = r_dropped;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_scan;
        w_wr_en     = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            fowq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_id      = w_id;
                    n_denied  = !w_grant;
                    n_queued  = 1'b0;
                    n_dropped = 1'b0;
                    if (w_grant) begin
                        if (!r_owner_vld) begin
                            n_owner     = w_id;
                            n_owner_vld = 1'b1;
                        end
                        if (i_req.finished) begin
                            if (r_count == '0) begin
                                n_owner     = '0;
                                n_owner_vld = 1'b0;
                                n_state     = fowq_pkg::ST_OUT;
                            end else begin
                                // fetch the oldest waiting id
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_head;
                                n_state   = fowq_pkg::ST_POP;
                            end
                        end else begin
                            n_state = fowq_pkg::ST_OUT;
                        end
                    end else begin
                        n_scan   = r_head;
                        n_rd_vld = 1'b0;
                        n_state  = fowq_pkg::ST_SCAN;
                    end
                end
            end
            fowq_pkg::ST_SCAN: begin
                if (w_hit) begin
                    // already waiting
                    n_rd_vld = 1'b0;
                    n_state  = fowq_pkg::ST_OUT;
                end else if (r_scan == r_tail) begin
                    // not found: append unless the ring is full
                    n_rd_vld = 1'b0;
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        w_wr_en  = 1'b1;
                        n_tail   = w_tail_nx;
                        n_count  = r_count + 1'b1;
                        n_queued = 1'b1;
                    end
                    n_state = fowq_pkg::ST_OUT;
                end else begin
                    w_rd_en  = 1'b1;
                    n_scan   = w_scan_nx;
                    n_rd_vld = 1'b1;
                end
            end
            fowq_pkg::ST_POP: begin
                n_owner = r_ring_q;
                n_head  = w_head_nx;
                n_count = r_count - 1'b1;
                n_state = fowq_pkg::ST_OUT;
            end
            fowq_pkg::ST_OUT: begin
                if (w_free) begin
                    w_load  = 1'b1;
                    n_state = fowq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fowq_pkg::ST_IDLE;
            end
        endcase
    end

    // queue memory; a write always ends an item, so no read overlaps it
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ring[r_tail] <= r_id;
        end
        if (w_rd_en) begin
            r_ring_q <= r_ring[w_rd_addr];
        end
    end

    // result fields from the settled state
    assign w_result.denied        = r_denied;
    assign w_result.owner_id      = r_owner_vld ? OID_W'(r_owner) : '0;
    assign w_result.owner_valid   = r_owner_vld;
    assign w_result.newly_queued  = r_queued;
    assign w_result.dropped_full  = r_dropped;
    assign w_result.waiting_count = CNT_W'(r_count);

    fowq_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_result),
        .o_free   (w_free),
        .o_res    (o_res)
    );

    // fill count agrees with the ring pointers
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail >= r_head) ? (int'(r_count) == int'(r_tail) - int'(r_head))
                           : (int'(r_count) == int'(r_tail) + QUEUE_DEPTH - int'(r_head)))
        else $error("wait count out of step with ring pointers");

    // nobody waits while the resource is idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_owner_vld |-> (r_count == '0))
        else $error("wait queue not empty with no owner");

    // idle owner register reads as zero
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_owner_vld |-> (r_owner == '0))
        else $error("owner id not cleared when idle");

    // an append never lands on a full ring
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (r_count != '0) && (r_tail != r_head))
        else $error("append overran the wait queue");

    // a pop only happens with entries waiting
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fowq_pkg::ST_POP) |-> (r_count != '0))
        else $error("handover from an empty wait queue");

endmodule
